@@ hdl/gsop_pkg.sv @@
// Shared widths, constants and controller/datapath interface types for the offset planner.
package gsop_pkg;

    localparam int SIZE_W      = 32;
    localparam int POS_W       = 16;
    localparam int OFF_W       = 38;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int STORE_DEPTH = 64;
    localparam int MAX_REQ_DEF = 64;

    typedef struct packed {
        logic load;
        logic plan_init;
        logic scan_step;
        logic fetch;
        logic latch;
        logic walk;
        logic commit;
        logic insert;
        logic round_next;
        logic out_issue;
        logic out_next;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic walk_done;
        logic ins_done;
        logic rounds_last;
        logic out_last;
    } sts_t;

endpackage

@@ hdl/gsop_ctrl.sv @@
// Planner controller: sequences load, pick, walk, insert and result phases.
module gsop_ctrl
    import gsop_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_is_final,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [8:0] {
        ST_LOAD     = 9'b000000001,
        ST_SCAN     = 9'b000000010,
        ST_FETCH    = 9'b000000100,
        ST_LATCH    = 9'b000001000,
        ST_WALK     = 9'b000010000,
        ST_COMMIT   = 9'b000100000,
        ST_INSERT   = 9'b001000000,
        ST_OUT_RD   = 9'b010000000,
        ST_OUT_SHOW = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_is_final) begin
                        cmd.plan_init = 1'b1;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_LATCH;
            end
            ST_LATCH: begin
                cmd.latch  = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                cmd.walk = 1'b1;
                if (sts.walk_done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_INSERT;
            end
            ST_INSERT: begin
                cmd.insert = 1'b1;
                if (sts.ins_done) begin
                    cmd.round_next = 1'b1;
                    state_next     = sts.rounds_last ? ST_OUT_RD : ST_SCAN;
                end
            end
            ST_OUT_RD: begin
                cmd.out_issue = 1'b1;
                state_next    = ST_OUT_SHOW;
            end
            ST_OUT_SHOW: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.out_next = 1'b1;
                    state_next   = sts.out_last ? ST_LOAD : ST_OUT_RD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

@@ hdl/gsop_dp.sv @@
// Planner datapath: request stores, offset-ordered ring, gap search and result registers.
module gsop_dp
    import gsop_pkg::*;
#(
    parameter int MAX_REQUESTS = MAX_REQ_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic [SIZE_W-1:0] s_req_size,
    input  logic [POS_W-1:0]  s_live_first,
    input  logic [POS_W-1:0]  s_live_end,
    output logic [IDX_W-1:0]  m_req_index,
    output logic [OFF_W-1:0]  m_placed_offset,
    output logic              m_run_last,
    output logic [SIZE_W-1:0] m_max_req_size,
    output logic [OFF_W-1:0]  m_peak_usage
);

    logic [SIZE_W-1:0] size_mem  [STORE_DEPTH];
    logic [POS_W-1:0]  first_mem [STORE_DEPTH];
    logic [POS_W-1:0]  end_mem   [STORE_DEPTH];
    logic [OFF_W-1:0]  off_mem   [STORE_DEPTH];

    logic [OFF_W-1:0]  r_off  [STORE_DEPTH];
    logic [OFF_W-1:0]  r_kend [STORE_DEPTH];
    logic [POS_W-1:0]  r_first[STORE_DEPTH];
    logic [POS_W-1:0]  r_end  [STORE_DEPTH];

    logic [CNT_W-1:0]  count_reg, sc_reg, round_reg, len_reg, step_reg, old_len_reg, out_idx_reg;
    logic [IDX_W-1:0]  rd_idx_reg, pick_reg, cur_idx_reg;
    logic              rd_vld_reg, have_reg, found_reg, inserted_reg;
    logic [SIZE_W-1:0] size_q, pick_size_reg, cur_size_reg, max_size_reg;
    logic [POS_W-1:0]  first_q, end_q, cur_first_reg, cur_end_reg;
    logic [OFF_W-1:0]  off_q, prev_reg, best_gap_reg, best_off_reg;
    logic [OFF_W-1:0]  new_off_reg, new_kend_reg, usage_reg;
    logic [STORE_DEPTH-1:0] placed_reg;

    logic [POS_W-1:0]  ov_lo, ov_hi;
    logic              overlap, head_ge, fits, better, walk_act, rot, app;
    logic [OFF_W-1:0]  gap, final_off;

    always_ff @(posedge aclk) begin
        if (cmd.load && count_reg < CNT_W'(MAX_REQUESTS)) begin
            size_mem[count_reg[IDX_W-1:0]]  <= s_req_size;
            first_mem[count_reg[IDX_W-1:0]] <= s_live_first;
            end_mem[count_reg[IDX_W-1:0]]   <= s_live_end;
        end
        if (cmd.scan_step && sc_reg < count_reg) begin
            size_q <= size_mem[sc_reg[IDX_W-1:0]];
        end
        if (cmd.fetch) begin
            first_q <= first_mem[pick_reg];
            end_q   <= end_mem[pick_reg];
        end
        if (cmd.commit) begin
            off_mem[cur_idx_reg] <= final_off;
        end
        if (cmd.out_issue) begin
            off_q <= off_mem[out_idx_reg[IDX_W-1:0]];
        end
    end

    assign ov_lo    = (cur_first_reg > r_first[0]) ? cur_first_reg : r_first[0];
    assign ov_hi    = (cur_end_reg < r_end[0]) ? cur_end_reg : r_end[0];
    assign overlap  = ov_lo <= ov_hi;
    assign head_ge  = r_off[0] >= prev_reg;
    assign gap      = r_off[0] - prev_reg;
    assign fits     = head_ge && gap >= OFF_W'(cur_size_reg);
    assign better   = !found_reg || gap < best_gap_reg;
    assign walk_act = cmd.walk && step_reg < len_reg;
    assign final_off = found_reg ? best_off_reg : prev_reg;

    always_comb begin
        rot = 1'b0;
        app = 1'b0;
        if (walk_act) begin
            rot = 1'b1;
        end else if (cmd.insert && !(inserted_reg && step_reg == old_len_reg)) begin
            if (!inserted_reg && (step_reg == old_len_reg || r_off[0] > new_off_reg)) begin
                app = 1'b1;
            end else begin
                rot = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            if (rot && CNT_W'(i) + 1'b1 < len_reg && i < STORE_DEPTH - 1) begin
                r_off[i]   <= r_off[(i + 1) % STORE_DEPTH];
                r_kend[i]  <= r_kend[(i + 1) % STORE_DEPTH];
                r_first[i] <= r_first[(i + 1) % STORE_DEPTH];
                r_end[i]   <= r_end[(i + 1) % STORE_DEPTH];
            end else if (rot && CNT_W'(i) + 1'b1 == len_reg) begin
                r_off[i]   <= r_off[0];
                r_kend[i]  <= r_kend[0];
                r_first[i] <= r_first[0];
                r_end[i]   <= r_end[0];
            end else if (app && CNT_W'(i) == len_reg) begin
                r_off[i]   <= new_off_reg;
                r_kend[i]  <= new_kend_reg;
                r_first[i] <= cur_first_reg;
                r_end[i]   <= cur_end_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            cur_idx_reg   <= pick_reg;
            cur_size_reg  <= pick_size_reg;
            cur_first_reg <= first_q;
            cur_end_reg   <= end_q;
        end
        if (cmd.latch) begin
            prev_reg <= '0;
        end else if (walk_act && overlap && r_kend[0] > prev_reg) begin
            prev_reg <= r_kend[0];
        end
        if (walk_act && overlap && fits && better) begin
            best_gap_reg <= gap;
            best_off_reg <= prev_reg;
        end
        if (cmd.commit) begin
            new_off_reg  <= final_off;
            new_kend_reg <= final_off + OFF_W'(cur_size_reg);
        end
        if (cmd.scan_step && rd_vld_reg && !placed_reg[rd_idx_reg]
                && (!have_reg || size_q > pick_size_reg)) begin
            pick_reg      <= rd_idx_reg;
            pick_size_reg <= size_q;
        end
        rd_idx_reg <= sc_reg[IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            sc_reg       <= '0;
            round_reg    <= '0;
            len_reg      <= '0;
            step_reg     <= '0;
            old_len_reg  <= '0;
            out_idx_reg  <= '0;
            rd_vld_reg   <= 1'b0;
            have_reg     <= 1'b0;
            found_reg    <= 1'b0;
            inserted_reg <= 1'b0;
            placed_reg   <= '0;
            usage_reg    <= '0;
            max_size_reg <= '0;
        end else begin
            if (cmd.load && count_reg < CNT_W'(MAX_REQUESTS)) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.plan_init) begin
                placed_reg   <= '0;
                len_reg      <= '0;
                usage_reg    <= '0;
                max_size_reg <= '0;
                round_reg    <= '0;
                out_idx_reg  <= '0;
            end
            if (cmd.plan_init || cmd.round_next) begin
                sc_reg     <= '0;
                rd_vld_reg <= 1'b0;
                have_reg   <= 1'b0;
            end else if (cmd.scan_step) begin
                rd_vld_reg <= sc_reg < count_reg;
                if (sc_reg < count_reg) begin
                    sc_reg <= sc_reg + 1'b1;
                end
                if (rd_vld_reg && !placed_reg[rd_idx_reg]
                        && (!have_reg || size_q > pick_size_reg)) begin
                    have_reg <= 1'b1;
                end
            end
            if (cmd.latch) begin
                step_reg  <= '0;
                found_reg <= 1'b0;
            end else if (walk_act) begin
                step_reg <= step_reg + 1'b1;
                if (overlap && fits && better) begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.commit) begin
                placed_reg[cur_idx_reg] <= 1'b1;
                old_len_reg  <= len_reg;
                step_reg     <= '0;
                inserted_reg <= 1'b0;
                if (cur_size_reg > max_size_reg) begin
                    max_size_reg <= cur_size_reg;
                end
            end
            if (cmd.insert) begin
                if (new_kend_reg > usage_reg) begin
                    usage_reg <= new_kend_reg;
                end
                if (app) begin
                    inserted_reg <= 1'b1;
                    len_reg      <= len_reg + 1'b1;
                end else if (rot) begin
                    step_reg <= step_reg + 1'b1;
                end
            end
            if (cmd.round_next) begin
                round_reg <= round_reg + 1'b1;
            end
            if (cmd.out_next) begin
                if (out_idx_reg + 1'b1 == count_reg) begin
                    out_idx_reg <= '0;
                    count_reg   <= '0;
                end else begin
                    out_idx_reg <= out_idx_reg + 1'b1;
                end
            end
        end
    end

    assign sts.scan_done   = sc_reg == count_reg && !rd_vld_reg;
    assign sts.walk_done   = step_reg == len_reg;
    assign sts.ins_done    = inserted_reg && step_reg == old_len_reg;
    assign sts.rounds_last = round_reg + 1'b1 == count_reg;
    assign sts.out_last    = out_idx_reg + 1'b1 == count_reg;

    assign m_req_index     = out_idx_reg[IDX_W-1:0];
    assign m_placed_offset = off_q;
    assign m_run_last      = sts.out_last;
    assign m_max_req_size  = max_size_reg;
    assign m_peak_usage    = usage_reg;

`ifndef ASSERT_OFF
    a_ring_len_rounds: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_step |-> len_reg == round_reg)
        else $error("ring length differs from placed count");
    a_pick_unplaced: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fetch |-> have_reg && !placed_reg[pick_reg])
        else $error("picked request already placed");
    a_commit_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> placed_reg[$past(cur_idx_reg)])
        else $error("committed request not marked placed");
    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.round_next |-> len_reg == old_len_reg + 1'b1)
        else $error("insertion did not grow the ring by one");
`endif

endmodule

@@ hdl/greedy_size_offset_planner_core.sv @@
// Greedy-by-size offset planner: top level joining controller and datapath.
// Load: one cycle per request transaction, back to back; the final request starts planning.
// Planning: n rounds for n requests; each scans the sizes of all n and picks the largest unplaced,
// then walks and inserts into the ring of the r already placed, read only at its single head port.
// Results: after planning, one per request in index order; the next is read after m_ready takes one.
// Reset: synchronous, active low; clears counts, placed flags and state, store contents undefined.
module greedy_size_offset_planner_core
    import gsop_pkg::*;
#(
    parameter int MAX_REQUESTS = MAX_REQ_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [SIZE_W-1:0] s_req_size,
    input  logic [POS_W-1:0]  s_live_first,
    input  logic [POS_W-1:0]  s_live_end,
    input  logic              s_is_final,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [IDX_W-1:0]  m_req_index,
    output logic [OFF_W-1:0]  m_placed_offset,
    output logic              m_run_last,
    output logic [SIZE_W-1:0] m_max_req_size,
    output logic [OFF_W-1:0]  m_peak_usage
);

    cmd_t cmd;
    sts_t sts;

    gsop_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_is_final (s_is_final),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    gsop_dp #(
        .MAX_REQUESTS (MAX_REQUESTS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_req_size      (s_req_size),
        .s_live_first    (s_live_first),
        .s_live_end      (s_live_end),
        .m_req_index     (m_req_index),
        .m_placed_offset (m_placed_offset),
        .m_run_last      (m_run_last),
        .m_max_req_size  (m_max_req_size),
        .m_peak_usage    (m_peak_usage)
    );

`ifndef ASSERT_OFF
    a_no_overlap_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result channels active together");
`endif

endmodule
